/* sv/sap_pkg.sv */
// Shared constants and types for the sandpile avalanche relaxer.
package sap_pkg;

    localparam int GRID_SIZE    = 64;
    localparam int ROW_W        = $clog2(GRID_SIZE);
    localparam int STEP_W       = $clog2(GRID_SIZE + 1);
    localparam int COORD_W      = 6;
    localparam int COUNT_W      = 32;
    localparam int HEIGHT_W     = 3;
    localparam int TOPPLE_BIT   = 2;
    localparam int TOPPLE_LIMIT = 4;
    localparam int RESET_HEIGHT = 3;

    typedef logic [HEIGHT_W-1:0] t_height;
    typedef logic [GRID_SIZE-1:0][HEIGHT_W-1:0] t_row;

    typedef struct packed {
        logic clear;
        logic step;
        logic drain;
    } t_cell_ctl;

endpackage

/* sv/sap_cell.sv */
// One column cell: holds two grid rows of its column and a toppling counter.
module sap_cell
    import sap_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cell_ctl          i_ctl,
    input  t_height            i_next_h,
    input  logic               i_left_k,
    input  logic               i_right_k,
    input  logic [COUNT_W-1:0] i_cnt_in,
    output logic               o_k,
    output t_height            o_new_h,
    output logic [COUNT_W-1:0] o_cnt
);

    t_height            r_prev;
    t_height            r_cur;
    logic [COUNT_W-1:0] r_cnt;

    assign o_k   = r_cur[TOPPLE_BIT];
    assign o_cnt = r_cnt;

    assign o_new_h = HEIGHT_W'(r_cur[TOPPLE_BIT-1:0]) + HEIGHT_W'(r_prev[TOPPLE_BIT])
                   + HEIGHT_W'(i_next_h[TOPPLE_BIT]) + HEIGHT_W'(i_left_k)
                   + HEIGHT_W'(i_right_k);

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_prev <= '0;
            r_cur  <= '0;
        end else if (i_ctl.step) begin
            r_prev <= r_cur;
            r_cur  <= i_next_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.drain) begin
            r_cnt <= i_cnt_in;
        end else if (i_ctl.step && r_cur[TOPPLE_BIT] && (r_cnt != '1)) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

endmodule

/* sv/sap_chain.sv */
// Row of column cells that exchange toppling flags and shift counters along the row.
module sap_chain
    import sap_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cell_ctl          i_ctl,
    input  t_row               i_next_row,
    output t_row               o_new_row,
    output logic               o_any_k,
    output logic [COUNT_W-1:0] o_cnt_head
);

    logic [GRID_SIZE-1:0]              k_vec;
    logic [GRID_SIZE-1:0][COUNT_W-1:0] cnt_vec;

    for (genvar c = 0; c < GRID_SIZE; c++) begin : g_cell
        logic               left_k;
        logic               right_k;
        logic [COUNT_W-1:0] cnt_in;

        if (c == 0) begin : g_left_edge
            assign left_k = 1'b0;
        end else begin : g_left
            assign left_k = k_vec[c-1];
        end

        if (c == GRID_SIZE - 1) begin : g_right_edge
            assign right_k = 1'b0;
            assign cnt_in  = '0;
        end else begin : g_right
            assign right_k = k_vec[c+1];
            assign cnt_in  = cnt_vec[c+1];
        end

        sap_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (i_ctl),
            .i_next_h  (i_next_row[c]),
            .i_left_k  (left_k),
            .i_right_k (right_k),
            .i_cnt_in  (cnt_in),
            .o_k       (k_vec[c]),
            .o_new_h   (o_new_row[c]),
            .o_cnt     (cnt_vec[c])
        );
    end

    assign o_any_k    = |k_vec;
    assign o_cnt_head = cnt_vec[0];

endmodule

/* sv/sandpile_avalanche_relaxer.sv */
// Top level of the sandpile avalanche relaxer: row store, sweep sequencer and result register.
//
// The grid is kept one row per memory word, and a row of column cells relaxes it in sweeps:
// each sweep streams the rows through the cells at one row per cycle, reading the row below
// and writing back the relaxed row through separate read and write ports. Every cell that
// holds four or more grains at the start of a sweep topples once in that sweep, and sweeps
// repeat until one passes without a toppling. The per-column counts are then shifted out
// and summed. Rows carry valid bits cleared at reset, so the grid reads as three grains per
// cell with no clearing pass. One drop is worked on at a time; the result register lets a
// new drop be taken while the previous count still waits for transfer.
module sandpile_avalanche_relaxer
    import sap_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [COORD_W-1:0] i_drop_row,
    input  logic [COORD_W-1:0] i_drop_col,
    output logic               o_stall,
    output logic               o_valid,
    output logic [COUNT_W-1:0] o_topple_count,
    input  logic               i_stall
);

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_DROP_RD = 7'b0000010,
        ST_DROP_WR = 7'b0000100,
        ST_PRE     = 7'b0001000,
        ST_SWEEP   = 7'b0010000,
        ST_DRAIN   = 7'b0100000,
        ST_DONE    = 7'b1000000
    } t_state;

    localparam t_row RESET_ROW = {GRID_SIZE{HEIGHT_W'(RESET_HEIGHT)}};

    t_state              r_state;
    t_state              n_state;
    logic [ROW_W-1:0]    r_row_sel;
    logic [ROW_W-1:0]    r_col_sel;
    logic [STEP_W-1:0]   r_step;
    logic                r_busy;
    logic [COUNT_W-1:0]  r_result;
    logic                r_out_valid;
    logic [COUNT_W-1:0]  r_out_count;

    t_row                r_mem [GRID_SIZE];
    logic [GRID_SIZE-1:0] r_row_vld;
    t_row                r_rd_data;
    logic                r_rd_ok;

    logic                accept;
    logic                in_range;
    logic [ROW_W-1:0]    rd_addr;
    logic                wr_en;
    logic [ROW_W-1:0]    wr_addr;
    t_row                wr_data;
    t_row                row_in;
    t_row                drop_row_out;
    t_height             old_h;
    t_row                next_row;
    t_cell_ctl           cell_ctl;
    t_row                new_row;
    logic                any_k;
    logic [COUNT_W-1:0]  cnt_head;
    logic [COUNT_W:0]    acc_sum;
    logic                out_free;

    assign o_stall        = (r_state != ST_IDLE);
    assign o_valid        = r_out_valid;
    assign o_topple_count = r_out_count;

    assign accept   = i_valid && (r_state == ST_IDLE);
    assign in_range = (32'(i_drop_row) < 32'(GRID_SIZE)) && (32'(i_drop_col) < 32'(GRID_SIZE));
    assign out_free = !r_out_valid || !i_stall;

    assign row_in = r_rd_ok ? r_rd_data : RESET_ROW;
    assign old_h  = row_in[r_col_sel];

    always_comb begin
        for (int c = 0; c < GRID_SIZE; c++) begin
            drop_row_out[c] = (ROW_W'(c) == r_col_sel) ? old_h + 1'b1 : row_in[c];
        end
    end

    assign next_row = (r_step == STEP_W'(GRID_SIZE)) ? '0 : row_in;

    always_comb begin
        rd_addr = ROW_W'(r_step + 1'b1);
        unique case (r_state)
            ST_IDLE:    rd_addr = ROW_W'(i_drop_row);
            ST_DROP_RD: rd_addr = r_row_sel;
            ST_PRE:     rd_addr = '0;
            default:    rd_addr = ROW_W'(r_step + 1'b1);
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = ROW_W'(r_step - 1'b1);
        wr_data = new_row;
        if (r_state == ST_DROP_WR) begin
            wr_en   = 1'b1;
            wr_addr = r_row_sel;
            wr_data = drop_row_out;
        end else if ((r_state == ST_SWEEP) && (r_step != '0)) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_ok   <= 1'b0;
        end else begin
            if (wr_en) begin
                r_row_vld[wr_addr] <= 1'b1;
            end
            r_rd_ok <= r_row_vld[rd_addr];
        end
    end

    always_comb begin
        cell_ctl       = '0;
        cell_ctl.clear = (r_state == ST_PRE);
        cell_ctl.step  = (r_state == ST_SWEEP);
        cell_ctl.drain = (r_state == ST_DRAIN);
    end

    sap_chain u_chain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (cell_ctl),
        .i_next_row (next_row),
        .o_new_row  (new_row),
        .o_any_k    (any_k),
        .o_cnt_head (cnt_head)
    );

    assign acc_sum = {1'b0, r_result} + {1'b0, cnt_head};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = in_range ? ST_DROP_RD : ST_DONE;
                end
            end
            ST_DROP_RD: n_state = ST_DROP_WR;
            ST_DROP_WR: begin
                n_state = (old_h == t_height'(RESET_HEIGHT)) ? ST_PRE : ST_DONE;
            end
            ST_PRE: n_state = ST_SWEEP;
            ST_SWEEP: begin
                if (r_step == STEP_W'(GRID_SIZE)) begin
                    n_state = (r_busy || any_k) ? ST_PRE : ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (r_step == STEP_W'(GRID_SIZE - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_row_sel <= ROW_W'(i_drop_row);
            r_col_sel <= ROW_W'(i_drop_col);
            r_result  <= '0;
        end
        unique case (r_state)
            ST_PRE: begin
                r_step <= '0;
                r_busy <= 1'b0;
            end
            ST_SWEEP: begin
                r_busy <= r_busy || any_k;
                r_step <= (r_step == STEP_W'(GRID_SIZE)) ? '0 : r_step + 1'b1;
            end
            ST_DRAIN: begin
                r_step   <= r_step + 1'b1;
                r_result <= acc_sum[COUNT_W] ? '1 : acc_sum[COUNT_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DONE) && out_free) begin
            r_out_count <= r_result;
        end
    end

    a_counters_empty_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (cnt_head == '0))
        else $error("Column counters not emptied after an avalanche.");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == ST_DONE))
        else $error("Result became valid outside the completion state.");

    a_sweep_starts_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_SWEEP) && (r_step == '0)) |-> !any_k)
        else $error("Cells not cleared at the start of a sweep.");

endmodule

/* sim/sandpile_avalanche_relaxer_test.sv */
// Self-checking testbench for the sandpile avalanche relaxer: grain drops and topple counts.
module sandpile_avalanche_relaxer_test
    import sap_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_HALF_NS  = 6;
    localparam int          RESET_CYCLES = 5;
    localparam int          HOLD_CYCLES  = 40000;
    localparam int          HOLD_AFTER   = 12;
    localparam int          TAIL_CYCLES  = 300;
    localparam int          PHASE_DROPS  = 30;
    localparam longint      TIMEOUT_NS   = 64'd20_000_000 * 12;
    localparam int          CELLS        = GRID_SIZE * GRID_SIZE;
    localparam int unsigned COORD_MAX    = (1 << COORD_W) - 1;

    typedef enum logic [1:0] {
        PH_STEADY,
        PH_SEND_GAPS,
        PH_RECV_STALLS,
        PH_BOTH_GAPS
    } t_idle_phase;

    typedef struct {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        t_idle_phase        phase;
        logic               drain_first;
    } t_grain_drop;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               drv_valid = 1'b0;
    logic [COORD_W-1:0] drv_row   = '0;
    logic [COORD_W-1:0] drv_col   = '0;
    logic               rcv_stall = 1'b0;
    logic               hold_on   = 1'b0;
    t_idle_phase        cur_phase = PH_STEADY;

    logic               dut_stall;
    logic               dut_valid;
    logic [COUNT_W-1:0] dut_count;

    t_grain_drop        drop_queue[$];
    logic [COUNT_W-1:0] expected_counts[$];
    int unsigned        pile_height[CELLS];
    int unsigned        unstable_cells[$];

    int                 n_drops    = 0;
    int                 n_results  = 0;
    int                 n_stable   = 0;
    int                 n_errors   = 0;
    longint unsigned    all_topples = 0;

    sandpile_avalanche_relaxer u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (drv_valid),
        .i_drop_row     (drv_row),
        .i_drop_col     (drv_col),
        .o_stall        (dut_stall),
        .o_valid        (dut_valid),
        .o_topple_count (dut_count),
        .i_stall        (rcv_stall)
    );

    function automatic int unsigned idle_pct(input t_idle_phase phase, input logic receiver_side);
        case (phase)
            PH_SEND_GAPS:   return receiver_side ? 0 : 49;
            PH_RECV_STALLS: return receiver_side ? 49 : 0;
            PH_BOTH_GAPS:   return 22;
            default:        return 0;
        endcase
    endfunction

    function automatic void pass_grains(input int unsigned idx, input int unsigned k);
        if (pile_height[idx] < TOPPLE_LIMIT && pile_height[idx] + k >= TOPPLE_LIMIT) begin
            unstable_cells.push_back(idx);
        end
        pile_height[idx] += k;
    endfunction

    function automatic logic [COUNT_W-1:0] predict_avalanche(input logic [COORD_W-1:0] row,
                                                             input logic [COORD_W-1:0] col);
        longint unsigned total;
        int unsigned     idx;
        int unsigned     r;
        int unsigned     c;
        int unsigned     k;
        total = 0;
        if (row >= GRID_SIZE || col >= GRID_SIZE) begin
            return '0;
        end
        idx = row * GRID_SIZE + col;
        pass_grains(idx, 1);
        while (unstable_cells.size() > 0) begin
            idx = unstable_cells.pop_back();
            k   = pile_height[idx] / TOPPLE_LIMIT;
            pile_height[idx] -= k * TOPPLE_LIMIT;
            total += k;
            r = idx / GRID_SIZE;
            c = idx % GRID_SIZE;
            if (r > 0) begin
                pass_grains(idx - GRID_SIZE, k);
            end
            if (r < GRID_SIZE - 1) begin
                pass_grains(idx + GRID_SIZE, k);
            end
            if (c > 0) begin
                pass_grains(idx - 1, k);
            end
            if (c < GRID_SIZE - 1) begin
                pass_grains(idx + 1, k);
            end
        end
        if (total > 64'hFFFF_FFFF) begin
            total = 64'hFFFF_FFFF;
        end
        return total[COUNT_W-1:0];
    endfunction

    task automatic queue_drop(input int unsigned row, input int unsigned col,
                              input t_idle_phase phase, input logic drain_first);
        t_grain_drop d;
        d.row         = row[COORD_W-1:0];
        d.col         = col[COORD_W-1:0];
        d.phase       = phase;
        d.drain_first = drain_first;
        drop_queue.push_back(d);
    endtask

    task automatic report_mismatch(input string what, input logic [COUNT_W-1:0] got,
                                   input logic [COUNT_W-1:0] want);
        $display("ERROR at %0t: result %0d, %s: got %0d, want %0d",
                 $realtime, n_results, what, got, want);
        n_errors++;
    endtask

    initial begin
        forever #(CLK_HALF_NS) clk = ~clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Timeout after %0d drops and %0d results", n_drops, n_results);
        $display("Mismatches found");
        $finish;
    end

    initial begin
        wait (n_drops >= HOLD_AFTER);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
    end

    always @(posedge clk) begin : drive_drops
        t_grain_drop nxt;
        logic        offer;
        offer = 1'b0;
        if (!rst_n) begin
            drv_valid <= 1'b0;
        end else if (!drv_valid || !dut_stall) begin
            if (drv_valid) begin
                expected_counts.push_back(predict_avalanche(drv_row, drv_col));
                n_drops++;
            end
            if (drop_queue.size() > 0) begin
                nxt = drop_queue[0];
                if (nxt.drain_first && expected_counts.size() != 0) begin
                    offer = 1'b0;
                end else if ($urandom_range(99) < idle_pct(nxt.phase, 1'b0)) begin
                    offer = 1'b0;
                end else begin
                    offer = 1'b1;
                    void'(drop_queue.pop_front());
                end
            end
            if (offer) begin
                drv_row   <= nxt.row;
                drv_col   <= nxt.col;
                cur_phase <= nxt.phase;
            end
            drv_valid <= offer;
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            rcv_stall <= 1'b0;
        end else begin
            rcv_stall <= hold_on || ($urandom_range(99) < idle_pct(cur_phase, 1'b1));
        end
    end

    always @(posedge clk) begin : check_counts
        logic [COUNT_W-1:0] want;
        if (rst_n && dut_valid && !rcv_stall) begin
            if (expected_counts.size() == 0) begin
                report_mismatch("count with no drop waiting", dut_count, '0);
            end else begin
                want = expected_counts.pop_front();
                if (dut_count !== want) begin
                    report_mismatch("topple_count", dut_count, want);
                end
            end
            if (dut_count == 0) begin
                n_stable++;
            end
            all_topples += dut_count;
            n_results++;
        end
    end

    initial begin : run_test
        int unsigned row;
        int unsigned col;
        int unsigned band;
        int unsigned mode;
        int unsigned last_row;
        int unsigned last_col;
        t_idle_phase ph;
        for (int i = 0; i < CELLS; i++) begin
            pile_height[i] = RESET_HEIGHT;
        end

        queue_drop(0, 0, PH_STEADY, 1'b0);
        queue_drop(0, COORD_MAX, PH_STEADY, 1'b0);
        queue_drop(COORD_MAX, 0, PH_STEADY, 1'b0);
        queue_drop(COORD_MAX, COORD_MAX, PH_STEADY, 1'b0);
        queue_drop(0, 0, PH_STEADY, 1'b0);
        queue_drop(31, 31, PH_STEADY, 1'b0);
        queue_drop(32, 32, PH_STEADY, 1'b0);
        queue_drop(31, 31, PH_STEADY, 1'b0);
        queue_drop(0, 32, PH_STEADY, 1'b0);
        queue_drop(32, 0, PH_STEADY, 1'b0);
        queue_drop(COORD_MAX, 31, PH_STEADY, 1'b0);
        queue_drop(31, COORD_MAX, PH_STEADY, 1'b0);
        queue_drop(21, 42, PH_STEADY, 1'b0);
        queue_drop(42, 21, PH_STEADY, 1'b0);
        queue_drop(1, 1, PH_STEADY, 1'b0);
        queue_drop(62, 62, PH_STEADY, 1'b0);
        queue_drop(1, 62, PH_STEADY, 1'b0);
        queue_drop(62, 1, PH_STEADY, 1'b0);
        for (int i = 0; i < 4; i++) begin
            queue_drop(10, 10, PH_STEADY, 1'b0);
        end

        last_row = 10;
        last_col = 10;
        for (int p = 0; p < 4; p++) begin
            ph = t_idle_phase'(p);
            for (int i = 0; i < PHASE_DROPS; i++) begin
                mode = $urandom_range(9);
                if (mode < 5) begin
                    band = $urandom_range(3);
                    row  = $urandom_range(1) ? band : COORD_MAX - band;
                    col  = $urandom_range(COORD_MAX);
                    if ($urandom_range(1)) begin
                        band = row;
                        row  = col;
                        col  = band;
                    end
                end else if (mode < 8) begin
                    row = $urandom_range(COORD_MAX);
                    col = $urandom_range(COORD_MAX);
                end else begin
                    row = last_row;
                    col = last_col;
                end
                queue_drop(row, col, ph, i == 0);
                last_row = row;
                last_col = col;
            end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        wait (drop_queue.size() == 0 && !drv_valid);
        wait (expected_counts.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d grain drops on corners, edges, centre and repeated cells",
                 n_drops);
        $display("under four handshake patterns: %0d counts checked, %0d stable, %0d topplings",
                 n_results, n_stable, all_topples);
        if (n_errors == 0 && expected_counts.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
